### hw/rtl/cdcnt_pkg.sv
// Shared types, widths and codes of the coin dispense counter.
package cdcnt_pkg;

  localparam int unsigned CmdW   = 4;
  localparam int unsigned CountW = 16;
  localparam int unsigned TimerW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = TimerW;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  localparam logic [TimerW-1:0] TimeoutReset  = TimerW'(10000);
  localparam logic [TimerW-1:0] IntervalReset = TimerW'(1000);

  typedef enum logic [CmdW-1:0] {
    CMD_TICK        = 4'd0,
    CMD_COIN        = 4'd1,
    CMD_DISPENSE    = 4'd2,
    CMD_STOP        = 4'd3,
    CMD_RESET       = 4'd4,
    CMD_GET         = 4'd5,
    CMD_CLR_STATUS  = 4'd6,
    CMD_CLR_EVENT   = 4'd7,
    CMD_TAKE_COIN   = 4'd8
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_INTERVAL  = 2'd1,
    CFG_HAS_RELAY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TimerW-1:0] timeout_ticks;
    logic [TimerW-1:0] status_interval_ticks;
    logic              has_relay;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CountW-1:0] target;
    logic              active;
    logic              reached;
    logic              timed_out;
    logic [TimerW-1:0] idle_timer;
    logic [TimerW-1:0] report_timer;
    logic              report;
    logic              event_flag;
    logic              coin_seen;
    logic              relay;
  } state_t;

endpackage

### hw/rtl/cdcnt_if.sv
// Command and result channel interfaces of the coin dispense counter.
interface cdcnt_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [cdcnt_pkg::CmdW-1:0]    cmd;
  logic [cdcnt_pkg::CountW-1:0]  amount;

  modport source (output valid, output cmd, output amount, input ready);
  modport sink (input valid, input cmd, input amount, output ready);
endinterface

interface cdcnt_res_if;
  logic                          valid;
  logic                          ready;
  logic [cdcnt_pkg::CountW-1:0]  coin_count;
  logic [cdcnt_pkg::CountW-1:0]  target_count;
  logic                          dispensing;
  logic                          goal_met;
  logic                          timed_out;
  logic                          relay_on;
  logic                          status_pending;
  logic                          event_pending;
  logic                          new_coin;

  modport source (
    output valid, output coin_count, output target_count, output dispensing,
    output goal_met, output timed_out, output relay_on,
    output status_pending, output event_pending, output new_coin,
    input ready
  );
  modport sink (
    input valid, input coin_count, input target_count, input dispensing,
    input goal_met, input timed_out, input relay_on,
    input status_pending, input event_pending, input new_coin,
    output ready
  );
endinterface

### hw/rtl/coin_dispense_counter_core.sv
// Top level of the coin dispense counter: state, configuration and result register.
//
//   channel   dir  handshake       payload
//   cmd_i     in   valid / ready   cmd, amount
//   res_o     out  valid / ready   coin_count .. new_coin, one per command
//   cfg_*     in   cfg_we_i        cfg_idx_i, cfg_wdata_i
//
// One command per cycle unless a held result stalls; result in the cycle after.
// The result register frees itself in the cycle it is taken, so cmd_i.ready
// stays high while res_o.ready is high.
// Reset clears all counter state, sets configuration to its defaults.
module coin_dispense_counter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cdcnt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cdcnt_pkg::CfgDataW-1:0]    cfg_wdata_i,
  cdcnt_cmd_if.sink                         cmd_i,
  cdcnt_res_if.source                       res_o
);

  cdcnt_pkg::cfg_t   cfg_q;
  cdcnt_pkg::state_t state_q;
  cdcnt_pkg::state_t state_d;
  logic              new_coin_d;
  logic              new_coin_q;
  logic              res_valid_q;
  logic              accept;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks         <= cdcnt_pkg::TimeoutReset;
      cfg_q.status_interval_ticks <= cdcnt_pkg::IntervalReset;
      cfg_q.has_relay             <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cdcnt_pkg::CFG_TIMEOUT:   cfg_q.timeout_ticks         <= cfg_wdata_i;
        cdcnt_pkg::CFG_INTERVAL:  cfg_q.status_interval_ticks <= cfg_wdata_i;
        cdcnt_pkg::CFG_HAS_RELAY: cfg_q.has_relay             <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  cdcnt_next u_next (
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd_i.cmd),
    .amount_i   (cmd_i.amount),
    .state_o    (state_d),
    .new_coin_o (new_coin_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      new_coin_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q    <= state_d;
        new_coin_q <= new_coin_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.coin_count     = state_q.count;
  assign res_o.target_count   = state_q.target;
  assign res_o.dispensing     = state_q.active;
  assign res_o.goal_met       = state_q.reached;
  assign res_o.timed_out      = state_q.timed_out;
  assign res_o.relay_on       = state_q.relay;
  assign res_o.status_pending = state_q.report;
  assign res_o.event_pending  = state_q.event_flag;
  assign res_o.new_coin       = new_coin_q;

endmodule

### hw/rtl/cdcnt_next.sv
// Next-state logic of the coin dispense counter for one command.
module cdcnt_next (
  input  cdcnt_pkg::state_t               state_i,
  input  cdcnt_pkg::cfg_t                 cfg_i,
  input  logic [cdcnt_pkg::CmdW-1:0]      cmd_i,
  input  logic [cdcnt_pkg::CountW-1:0]    amount_i,
  output cdcnt_pkg::state_t               state_o,
  output logic                            new_coin_o
);

  logic [cdcnt_pkg::TimerW-1:0] idle_inc;
  logic [cdcnt_pkg::TimerW-1:0] report_inc;
  logic [cdcnt_pkg::CountW-1:0] count_inc;

  assign idle_inc   = (state_i.idle_timer < cdcnt_pkg::TimerMax) ?
                      state_i.idle_timer + cdcnt_pkg::TimerW'(1) : state_i.idle_timer;
  assign report_inc = (state_i.report_timer < cdcnt_pkg::TimerMax) ?
                      state_i.report_timer + cdcnt_pkg::TimerW'(1) : state_i.report_timer;
  assign count_inc  = (state_i.count < cdcnt_pkg::CountMax) ?
                      state_i.count + cdcnt_pkg::CountW'(1) : state_i.count;

  always_comb begin
    state_o    = state_i;
    new_coin_o = 1'b0;
    case (cmd_i)
      cdcnt_pkg::CMD_TICK: begin
        state_o.idle_timer   = idle_inc;
        state_o.report_timer = report_inc;
        if (state_i.active && report_inc >= cfg_i.status_interval_ticks) begin
          state_o.report       = 1'b1;
          state_o.report_timer = '0;
        end
        if (state_i.active && !state_i.reached && idle_inc >= cfg_i.timeout_ticks) begin
          state_o.timed_out  = 1'b1;
          state_o.active     = 1'b0;
          state_o.event_flag = 1'b1;
          if (cfg_i.has_relay) begin
            state_o.relay = 1'b0;
          end
        end
      end
      cdcnt_pkg::CMD_COIN: begin
        state_o.count      = count_inc;
        state_o.coin_seen  = 1'b1;
        state_o.idle_timer = '0;
        state_o.timed_out  = 1'b0;
        if (state_i.active && state_i.target != '0 && count_inc >= state_i.target) begin
          state_o.reached    = 1'b1;
          state_o.active     = 1'b0;
          state_o.event_flag = 1'b1;
          if (cfg_i.has_relay) begin
            state_o.relay = 1'b0;
          end
        end
      end
      cdcnt_pkg::CMD_DISPENSE: begin
        if (amount_i != '0) begin
          state_o.target       = amount_i;
          state_o.count        = '0;
          state_o.active       = 1'b1;
          state_o.reached      = 1'b0;
          state_o.timed_out    = 1'b0;
          state_o.idle_timer   = '0;
          state_o.report_timer = '0;
          state_o.report       = 1'b1;
          if (cfg_i.has_relay) begin
            state_o.relay = 1'b1;
          end
        end
      end
      cdcnt_pkg::CMD_STOP: begin
        state_o.active = 1'b0;
        state_o.report = 1'b1;
        if (cfg_i.has_relay) begin
          state_o.relay = 1'b0;
        end
      end
      cdcnt_pkg::CMD_RESET: begin
        state_o.count        = '0;
        state_o.coin_seen    = 1'b0;
        state_o.reached      = 1'b0;
        state_o.timed_out    = 1'b0;
        state_o.active       = 1'b0;
        state_o.target       = '0;
        state_o.idle_timer   = '0;
        state_o.report_timer = '0;
        state_o.report       = 1'b1;
      end
      cdcnt_pkg::CMD_GET: begin
        state_o.report = 1'b1;
      end
      cdcnt_pkg::CMD_CLR_STATUS: begin
        state_o.report = 1'b0;
      end
      cdcnt_pkg::CMD_CLR_EVENT: begin
        state_o.event_flag = 1'b0;
      end
      cdcnt_pkg::CMD_TAKE_COIN: begin
        new_coin_o        = state_i.coin_seen;
        state_o.coin_seen = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

### bench/testbench.sv
// Self-checking testbench for coin_dispense_counter_core with directed and random commands.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [cdcnt_pkg::CountW-1:0] coin_count;
    logic [cdcnt_pkg::CountW-1:0] target_count;
    logic                         dispensing;
    logic                         goal_met;
    logic                         timed_out;
    logic                         relay_on;
    logic                         status_pending;
    logic                         event_pending;
    logic                         new_coin;
  } status_t;

  class dispense_tracker;
    logic [cdcnt_pkg::TimerW-1:0] timeout_ticks;
    logic [cdcnt_pkg::TimerW-1:0] interval_ticks;
    logic                         has_relay;
    logic [cdcnt_pkg::CountW-1:0] count;
    logic [cdcnt_pkg::CountW-1:0] target;
    logic                         active;
    logic                         reached;
    logic                         timed_out;
    logic [cdcnt_pkg::TimerW-1:0] idle_timer;
    logic [cdcnt_pkg::TimerW-1:0] report_timer;
    logic                         report_req;
    logic                         event_flag;
    logic                         coin_seen;
    logic                         relay;
    status_t                      expected_status[$];
    int unsigned                  errors;
    int unsigned                  results_seen;

    function new();
      errors = 0;
      results_seen = 0;
      timeout_ticks = cdcnt_pkg::TimeoutReset;
      interval_ticks = cdcnt_pkg::IntervalReset;
      has_relay = 1'b1;
      count = '0;
      target = '0;
      active = 1'b0;
      reached = 1'b0;
      timed_out = 1'b0;
      idle_timer = '0;
      report_timer = '0;
      report_req = 1'b0;
      event_flag = 1'b0;
      coin_seen = 1'b0;
      relay = 1'b0;
    endfunction

    function void set_cfg(cdcnt_pkg::cfg_idx_e idx, logic [cdcnt_pkg::CfgDataW-1:0] data);
      case (idx)
        cdcnt_pkg::CFG_TIMEOUT:   timeout_ticks = data[cdcnt_pkg::TimerW-1:0];
        cdcnt_pkg::CFG_INTERVAL:  interval_ticks = data[cdcnt_pkg::TimerW-1:0];
        cdcnt_pkg::CFG_HAS_RELAY: has_relay = data[0];
        default: ;
      endcase
    endfunction

    function void switch_relay(logic on);
      if (has_relay) relay = on;
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    function void accept_cmd(logic [cdcnt_pkg::CmdW-1:0] cmd,
                             logic [cdcnt_pkg::CountW-1:0] amount);
      status_t s;
      logic    took;
      took = 1'b0;
      case (cmd)
        cdcnt_pkg::CMD_TICK: begin
          if (idle_timer != cdcnt_pkg::TimerMax)
            idle_timer = idle_timer + cdcnt_pkg::TimerW'(1);
          if (report_timer != cdcnt_pkg::TimerMax)
            report_timer = report_timer + cdcnt_pkg::TimerW'(1);
          if (active && report_timer >= interval_ticks) begin
            report_req = 1'b1;
            report_timer = '0;
          end
          if (active && !reached && idle_timer >= timeout_ticks) begin
            timed_out = 1'b1;
            active = 1'b0;
            switch_relay(1'b0);
            event_flag = 1'b1;
          end
        end
        cdcnt_pkg::CMD_COIN: begin
          if (count != cdcnt_pkg::CountMax) count = count + cdcnt_pkg::CountW'(1);
          coin_seen = 1'b1;
          idle_timer = '0;
          timed_out = 1'b0;
          if (active && target != '0 && count >= target) begin
            reached = 1'b1;
            active = 1'b0;
            switch_relay(1'b0);
            event_flag = 1'b1;
          end
        end
        cdcnt_pkg::CMD_DISPENSE: begin
          if (amount != '0) begin
            target = amount;
            count = '0;
            active = 1'b1;
            reached = 1'b0;
            timed_out = 1'b0;
            idle_timer = '0;
            report_timer = '0;
            switch_relay(1'b1);
            report_req = 1'b1;
          end
        end
        cdcnt_pkg::CMD_STOP: begin
          active = 1'b0;
          switch_relay(1'b0);
          report_req = 1'b1;
        end
        cdcnt_pkg::CMD_RESET: begin
          count = '0;
          coin_seen = 1'b0;
          reached = 1'b0;
          timed_out = 1'b0;
          active = 1'b0;
          target = '0;
          idle_timer = '0;
          report_timer = '0;
          report_req = 1'b1;
        end
        cdcnt_pkg::CMD_GET:        report_req = 1'b1;
        cdcnt_pkg::CMD_CLR_STATUS: report_req = 1'b0;
        cdcnt_pkg::CMD_CLR_EVENT:  event_flag = 1'b0;
        cdcnt_pkg::CMD_TAKE_COIN: begin
          took = coin_seen;
          coin_seen = 1'b0;
        end
        default: ;
      endcase
      s = {count, target, active, reached, timed_out, relay, report_req, event_flag, took};
      expected_status.push_back(s);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("result %0d: %0s got %0h, want %0h", results_seen, field, got, want);
    endtask

    task check_status(status_t got);
      status_t want;
      results_seen++;
      if (expected_status.size() == 0) begin
        report("result with nothing expected", '0, '0);
        return;
      end
      want = expected_status.pop_front();
      if (got.coin_count !== want.coin_count)
        report("coin_count", 32'(got.coin_count), 32'(want.coin_count));
      if (got.target_count !== want.target_count)
        report("target_count", 32'(got.target_count), 32'(want.target_count));
      if (got.dispensing !== want.dispensing)
        report("dispensing", 32'(got.dispensing), 32'(want.dispensing));
      if (got.goal_met !== want.goal_met)
        report("goal_met", 32'(got.goal_met), 32'(want.goal_met));
      if (got.timed_out !== want.timed_out)
        report("timed_out", 32'(got.timed_out), 32'(want.timed_out));
      if (got.relay_on !== want.relay_on)
        report("relay_on", 32'(got.relay_on), 32'(want.relay_on));
      if (got.status_pending !== want.status_pending)
        report("status_pending", 32'(got.status_pending), 32'(want.status_pending));
      if (got.event_pending !== want.event_pending)
        report("event_pending", 32'(got.event_pending), 32'(want.event_pending));
      if (got.new_coin !== want.new_coin)
        report("new_coin", 32'(got.new_coin), 32'(want.new_coin));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cdcnt_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [cdcnt_pkg::CfgDataW-1:0] cfg_wdata_i;
  bit                             calm;
  bit                             hold_req;

  cdcnt_cmd_if cmd_if ();
  cdcnt_res_if res_if ();

  dispense_tracker tracker = new();

  coin_dispense_counter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_cmd(input logic [cdcnt_pkg::CmdW-1:0] c,
                          input logic [cdcnt_pkg::CountW-1:0] a);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.cmd    <= c;
    cmd_if.amount <= a;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    tracker.accept_cmd(c, a);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned                  roll;
    logic [cdcnt_pkg::CmdW-1:0]   c;
    logic [cdcnt_pkg::CountW-1:0] a;
    roll = $urandom_range(0, 99);
    a = cdcnt_pkg::CountW'($urandom);
    if (roll < 34) c = cdcnt_pkg::CMD_TICK;
    else if (roll < 58) c = cdcnt_pkg::CMD_COIN;
    else if (roll < 66) begin
      c = cdcnt_pkg::CMD_DISPENSE;
      roll = $urandom_range(0, 9);
      if (roll == 0) a = '0;
      else if (roll < 8) a = cdcnt_pkg::CountW'($urandom_range(1, 6));
    end
    else if (roll < 69) c = cdcnt_pkg::CMD_STOP;
    else if (roll < 72) c = cdcnt_pkg::CMD_RESET;
    else if (roll < 77) c = cdcnt_pkg::CMD_GET;
    else if (roll < 82) c = cdcnt_pkg::CMD_CLR_STATUS;
    else if (roll < 88) c = cdcnt_pkg::CMD_CLR_EVENT;
    else if (roll < 94) c = cdcnt_pkg::CMD_TAKE_COIN;
    else c = cdcnt_pkg::CmdW'($urandom_range(9, 15));
    send_cmd(c, a);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic set_all_cfg(input logic [cdcnt_pkg::TimerW-1:0] timeout_v,
                             input logic [cdcnt_pkg::TimerW-1:0] interval_v,
                             input logic relay_v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= cdcnt_pkg::CFG_TIMEOUT;
    cfg_wdata_i <= timeout_v;
    @(negedge clk_i);
    tracker.set_cfg(cdcnt_pkg::CFG_TIMEOUT, timeout_v);
    cfg_idx_i   <= cdcnt_pkg::CFG_INTERVAL;
    cfg_wdata_i <= interval_v;
    @(negedge clk_i);
    tracker.set_cfg(cdcnt_pkg::CFG_INTERVAL, interval_v);
    cfg_idx_i   <= cdcnt_pkg::CFG_HAS_RELAY;
    cfg_wdata_i <= cdcnt_pkg::CfgDataW'(relay_v);
    @(negedge clk_i);
    tracker.set_cfg(cdcnt_pkg::CFG_HAS_RELAY, cdcnt_pkg::CfgDataW'(relay_v));
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      tracker.check_status({res_if.coin_count, res_if.target_count, res_if.dispensing,
                            res_if.goal_met, res_if.timed_out, res_if.relay_on,
                            res_if.status_pending, res_if.event_pending, res_if.new_coin});
  end

  initial begin
    int unsigned stall;
    int unsigned hold_left;
    logic        next_ready;
    stall = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        if (stall == 0) stall = pick_gap();
        if (stall > 0) begin
          stall--;
          next_ready = 1'b0;
        end else begin
          next_ready = 1'b1;
        end
      end
      res_if.ready <= next_ready;
    end
  end

  initial begin
    logic [cdcnt_pkg::TimerW-1:0] timeout_v;
    logic [cdcnt_pkg::TimerW-1:0] interval_v;
    logic                         relay_v;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = cdcnt_pkg::CFG_TIMEOUT;
    cfg_wdata_i   = '0;
    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = cdcnt_pkg::CMD_TICK;
    cmd_if.amount = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_cmd(cdcnt_pkg::CMD_TICK, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_TAKE_COIN, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_COIN, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_TAKE_COIN, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_DISPENSE, '0);
    send_cmd(cdcnt_pkg::CMD_DISPENSE, 16'd2);
    send_cmd(cdcnt_pkg::CMD_CLR_STATUS, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_COIN, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_COIN, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_CLR_EVENT, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_GET, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_DISPENSE, 16'd5);
    send_cmd(cdcnt_pkg::CMD_RESET, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_STOP, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CmdW'(9), cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CmdW'(15), cdcnt_pkg::CountW'($urandom));

    drain();
    set_all_cfg(cdcnt_pkg::TimerW'(1), cdcnt_pkg::TimerW'(1), 1'b0);
    send_cmd(cdcnt_pkg::CMD_DISPENSE, 16'd3);
    send_cmd(cdcnt_pkg::CMD_TICK, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_COIN, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_TICK, cdcnt_pkg::CountW'($urandom));

    drain();
    set_all_cfg('0, '0, 1'b1);
    send_cmd(cdcnt_pkg::CMD_DISPENSE, 16'd1);
    send_cmd(cdcnt_pkg::CMD_TICK, cdcnt_pkg::CountW'($urandom));
    send_cmd(cdcnt_pkg::CMD_CLR_STATUS, cdcnt_pkg::CountW'($urandom));

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          timeout_v = cdcnt_pkg::TimerW'($urandom_range(1, 20));
          interval_v = cdcnt_pkg::TimerW'($urandom_range(1, 10));
          relay_v = 1'b1;
        end
        1: begin
          timeout_v = cdcnt_pkg::TimerW'(1);
          interval_v = cdcnt_pkg::TimerW'(1);
          relay_v = 1'b0;
        end
        2: begin
          timeout_v = cdcnt_pkg::TimerMax;
          interval_v = cdcnt_pkg::TimerMax;
          relay_v = 1'b1;
        end
        3: begin
          timeout_v = cdcnt_pkg::TimerW'($urandom_range(3, 40));
          interval_v = cdcnt_pkg::TimerW'($urandom_range(2, 15));
          relay_v = 1'($urandom_range(0, 1));
        end
        4: begin
          timeout_v = cdcnt_pkg::TimerW'($urandom_range(1, 8));
          interval_v = cdcnt_pkg::TimerMax;
          relay_v = 1'b1;
        end
        default: begin
          timeout_v = cdcnt_pkg::TimerW'($urandom);
          interval_v = cdcnt_pkg::TimerW'($urandom_range(1, 5));
          relay_v = 1'b1;
        end
      endcase
      set_all_cfg(timeout_v, interval_v, relay_v);
      if (p == 1) hold_req = 1'b1;
      calm = 1'b1;
      for (int n = 0; n < 100; n++) begin
        if (n == 25) calm = 1'b0;
        if (p == 3 && n == 50) drain();
        send_random();
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
